// File: design/alu8f_pkg.sv
// alu8f_pkg: operation codes, flag layout and fixed constants of the 8-bit flag ALU
// no dependencies; imported by alu8f_core and alu_8bit_with_flags
`timescale 1ns / 1ps
`default_nettype none

package alu8f_pkg;

    // operation codes carried on the cmd field
    typedef enum logic [4:0] {
        CMD_ADD  = 5'd0,
        CMD_ADC  = 5'd1,
        CMD_SUB  = 5'd2,
        CMD_SBC  = 5'd3,
        CMD_AND  = 5'd4,
        CMD_XOR  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_CP   = 5'd7,
        CMD_INC  = 5'd8,
        CMD_DEC  = 5'd9,
        CMD_DAA  = 5'd10,
        CMD_CPL  = 5'd11,
        CMD_SCF  = 5'd12,
        CMD_CCF  = 5'd13,
        CMD_RLCA = 5'd14,
        CMD_RRCA = 5'd15,
        CMD_RLA  = 5'd16,
        CMD_RRA  = 5'd17
    } t_cmd;

    // flag nibble: bit3 z, bit2 n, bit1 h, bit0 c
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0] NIBBLE_MAX   = 4'hF;

endpackage

`default_nettype wire

// File: design/alu_8bit_with_flags.sv
// alu_8bit_with_flags: 8-bit accumulator alu with z/n/h/c flags, two register stages
// depends on alu8f_pkg and alu8f_core
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel: i_in_valid / o_in_stall carry one beat of cmd, acc, operand, flags;
//   a beat is taken on a rising edge with i_in_valid high and o_in_stall low
//   output channel: o_out_valid / i_out_stall carry the result byte and new flags;
//   the receiver takes a beat on an edge with o_out_valid high and i_out_stall low
//   path: a taken beat lands in the operand register, is evaluated by the alu core
//   and lands in the result register, from which it is offered on the output
//   throughput: one beat per cycle while the receiver does not stall, set by the
//   single pass through the alu core between the two registers
//   stall: when the receiver stalls, the result register holds its beat and the
//   operand register can still take one more beat; o_in_stall rises only when
//   both registers are full and the receiver is stalling
//   reset: i_rst_n is synchronous, active low; both stages are emptied, nothing
//   else is kept since the alu holds no state between beats
module alu_8bit_with_flags (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [4:0] i_cmd,
    input  wire logic [7:0] i_acc_in,
    input  wire logic [7:0] i_operand_in,
    input  wire logic [3:0] i_flags_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_result_byte,
    output logic [3:0]      o_flags_out
);
    import alu8f_pkg::*;

    // operand stage
    logic       r_in_valid;
    logic       n_in_valid;
    logic [4:0] r_cmd;
    logic [7:0] r_acc;
    logic [7:0] r_operand;
    t_flags     r_flags;

    // result stage
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_result;
    t_flags     r_flags_out;

    logic       w_out_adv;
    logic       w_in_adv;
    logic [7:0] w_result;
    t_flags     w_flags;

    // result stage moves when empty or when its beat is being taken
    assign w_out_adv  = ~r_out_valid | ~i_out_stall;
    // operand stage moves when empty or when it can pass its beat on
    assign w_in_adv   = ~r_in_valid | w_out_adv;
    assign o_in_stall = ~w_in_adv;

    always_comb begin
        n_in_valid  = w_in_adv ? i_in_valid : r_in_valid;
        n_out_valid = w_out_adv ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_adv) begin
            r_cmd     <= i_cmd;
            r_acc     <= i_acc_in;
            r_operand <= i_operand_in;
            r_flags   <= t_flags'(i_flags_in);
        end
        if (w_out_adv) begin
            r_result    <= w_result;
            r_flags_out <= w_flags;
        end
    end

    alu8f_core u_core (
        .i_cmd     (r_cmd),
        .i_acc     (r_acc),
        .i_operand (r_operand),
        .i_flags   (r_flags),
        .o_result  (w_result),
        .o_flags   (w_flags)
    );

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_result;
    assign o_flags_out   = r_flags_out;

`ifndef SYNTHESIS
    // upstream is held off only while both stages are full and downstream stalls
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled while a stage is free");

    // an operand beat that can move shows up on the output in the next cycle
    a_beat_reaches_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_adv) |=>
        (o_out_valid && o_result_byte == $past(w_result)
         && o_flags_out == $past(w_flags)))
        else $error("operand beat lost between stages");

    // a taken input beat is held in the operand stage next cycle
    a_accept_fills_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted beat dropped");

    // accumulator rotates always clear z
    a_rotate_clears_z : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_cmd == CMD_RLCA || r_cmd == CMD_RRCA
                        || r_cmd == CMD_RLA || r_cmd == CMD_RRA)) |-> !w_flags.z)
        else $error("rotate left z set");
`endif

endmodule

`default_nettype wire

// File: design/alu8f_core.sv
// alu8f_core: combinational datapath, one operation on one byte pair plus flags
// depends on alu8f_pkg
`timescale 1ns / 1ps
`default_nettype none

module alu8f_core (
    input  wire logic [4:0]        i_cmd,
    input  wire logic [7:0]        i_acc,
    input  wire logic [7:0]        i_operand,
    input  wire alu8f_pkg::t_flags i_flags,
    output logic [7:0]             o_result,
    output alu8f_pkg::t_flags      o_flags
);
    import alu8f_pkg::*;

    logic       add_cin;
    logic       sub_cin;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic [7:0] and_res;
    logic [7:0] xor_res;
    logic [7:0] or_res;
    logic [7:0] inc_res;
    logic [7:0] dec_res;
    logic       daa_hi;
    logic       daa_lo;
    logic [7:0] daa_adj;
    logic [7:0] daa_res;

    assign add_cin  = (i_cmd == CMD_ADC) & i_flags.c;
    assign sub_cin  = (i_cmd == CMD_SBC) & i_flags.c;
    assign add_sum  = {1'b0, i_acc} + {1'b0, i_operand} + {8'b0, add_cin};
    assign add_half = {1'b0, i_acc[3:0]} + {1'b0, i_operand[3:0]} + {4'b0, add_cin};
    // borrow shows up in the top bit of the widened difference
    assign sub_diff = {1'b0, i_acc} - {1'b0, i_operand} - {8'b0, sub_cin};
    assign sub_half = {1'b0, i_acc[3:0]} - {1'b0, i_operand[3:0]} - {4'b0, sub_cin};
    assign and_res  = i_acc & i_operand;
    assign xor_res  = i_acc ^ i_operand;
    assign or_res   = i_acc | i_operand;
    assign inc_res  = i_acc + 8'd1;
    assign dec_res  = i_acc - 8'd1;

    // decimal adjust: both corrections folded into one add or subtract
    assign daa_hi  = i_flags.n ? i_flags.c : (i_flags.c | (i_acc > DAA_HI_LIMIT));
    assign daa_lo  = i_flags.n ? i_flags.h : (i_flags.h | (i_acc[3:0] > DAA_LO_LIMIT));
    assign daa_adj = (daa_hi ? DAA_HI_ADJ : 8'h00) | (daa_lo ? DAA_LO_ADJ : 8'h00);
    assign daa_res = i_flags.n ? (i_acc - daa_adj) : (i_acc + daa_adj);

    always_comb begin
        o_result = i_acc;
        o_flags  = i_flags;
        case (i_cmd)
            CMD_ADD, CMD_ADC: begin
                o_result = add_sum[7:0];
                o_flags  = '{z: (add_sum[7:0] == 8'h00), n: 1'b0,
                             h: add_half[4], c: add_sum[8]};
            end
            CMD_SUB, CMD_SBC: begin
                o_result = sub_diff[7:0];
                o_flags  = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1,
                             h: sub_half[4], c: sub_diff[8]};
            end
            CMD_CP: begin
                o_flags  = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1,
                             h: sub_half[4], c: sub_diff[8]};
            end
            CMD_AND: begin
                o_result = and_res;
                o_flags  = '{z: (and_res == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_XOR: begin
                o_result = xor_res;
                o_flags  = '{z: (xor_res == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_OR: begin
                o_result = or_res;
                o_flags  = '{z: (or_res == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_INC: begin
                o_result = inc_res;
                o_flags  = '{z: (inc_res == 8'h00), n: 1'b0,
                             h: (i_acc[3:0] == NIBBLE_MAX), c: i_flags.c};
            end
            CMD_DEC: begin
                o_result = dec_res;
                o_flags  = '{z: (dec_res == 8'h00), n: 1'b1,
                             h: (i_acc[3:0] == 4'h0), c: i_flags.c};
            end
            CMD_DAA: begin
                o_result = daa_res;
                o_flags  = '{z: (daa_res == 8'h00), n: i_flags.n, h: 1'b0,
                             c: (i_flags.n ? i_flags.c : daa_hi)};
            end
            CMD_CPL: begin
                o_result = ~i_acc;
                o_flags  = '{z: i_flags.z, n: 1'b1, h: 1'b1, c: i_flags.c};
            end
            CMD_SCF: begin
                o_flags  = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            CMD_CCF: begin
                o_flags  = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: ~i_flags.c};
            end
            CMD_RLCA: begin
                o_result = {i_acc[6:0], i_acc[7]};
                o_flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[7]};
            end
            CMD_RRCA: begin
                o_result = {i_acc[0], i_acc[7:1]};
                o_flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[0]};
            end
            CMD_RLA: begin
                o_result = {i_acc[6:0], i_flags.c};
                o_flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[7]};
            end
            CMD_RRA: begin
                o_result = {i_flags.c, i_acc[7:1]};
                o_flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[0]};
            end
            default: begin
                // unused codes pass the accumulator and flags through
                o_result = i_acc;
                o_flags  = i_flags;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: dv/alu_8bit_with_flags_test.sv
// alu_8bit_with_flags_test: self-checking testbench of the 8-bit flag alu
// drives random and directed beats, predicts result byte and flags, checks each output beat
// depends on alu8f_pkg and alu_8bit_with_flags
`timescale 1ns / 1ps

module alu_8bit_with_flags_test;
    import alu8f_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;

    // one input beat
    typedef struct packed {
        logic [4:0] cmd;
        logic [7:0] acc;
        logic [7:0] opnd;
        logic [3:0] flags;
    } t_alu_beat;

    // one output beat
    typedef struct packed {
        logic [7:0] result_byte;
        logic [3:0] flags_out;
    } t_alu_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [4:0] i_cmd;
    logic [7:0] i_acc_in;
    logic [7:0] i_operand_in;
    logic [3:0] i_flags_in;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_result_byte;
    logic [3:0] o_flags_out;

    t_alu_beat   beat_queue[$];    // beats waiting for the driver
    t_alu_result result_queue[$];  // predicted outputs, oldest first
    t_alu_beat   next_beat;

    int  send_idle_pct = 0;
    int  out_stall_pct = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_request = 0;
    bit  hold_done = 0;
    bit  in_taken = 0;

    alu_8bit_with_flags dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_acc_in      (i_acc_in),
        .i_operand_in  (i_operand_in),
        .i_flags_in    (i_flags_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_byte (o_result_byte),
        .o_flags_out   (o_flags_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predicted result byte and flags of one beat
    function automatic t_alu_result alu_eval(t_alu_beat bt);
        t_flags      fin;
        t_flags      f;
        logic [7:0]  r;
        logic [8:0]  wide;
        logic [4:0]  nib;
        logic        cin;
        logic        c;
        t_alu_result res;
        fin = bt.flags;
        f = fin;
        r = bt.acc;
        cin = 1'b0;
        case (bt.cmd)
            CMD_ADD, CMD_ADC: begin
                if (bt.cmd == CMD_ADC) cin = fin.c;
                wide = {1'b0, bt.acc} + {1'b0, bt.opnd} + {8'd0, cin};
                nib = {1'b0, bt.acc[3:0]} + {1'b0, bt.opnd[3:0]} + {4'd0, cin};
                r = wide[7:0];
                f = '{z: (r == 8'd0), n: 1'b0, h: nib[4], c: wide[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                if (bt.cmd == CMD_SBC) cin = fin.c;
                // borrow shows up as the ninth and fifth bit of the differences
                wide = {1'b0, bt.acc} - {1'b0, bt.opnd} - {8'd0, cin};
                nib = {1'b0, bt.acc[3:0]} - {1'b0, bt.opnd[3:0]} - {4'd0, cin};
                r = wide[7:0];
                f = '{z: (r == 8'd0), n: 1'b1, h: nib[4], c: wide[8]};
                if (bt.cmd == CMD_CP) r = bt.acc;
            end
            CMD_AND: begin
                r = bt.acc & bt.opnd;
                f = '{z: (r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_XOR: begin
                r = bt.acc ^ bt.opnd;
                f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_OR: begin
                r = bt.acc | bt.opnd;
                f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_INC: begin
                r = bt.acc + 8'd1;
                f = '{z: (r == 8'd0), n: 1'b0, h: (bt.acc[3:0] == NIBBLE_MAX), c: fin.c};
            end
            CMD_DEC: begin
                r = bt.acc - 8'd1;
                f = '{z: (r == 8'd0), n: 1'b1, h: (bt.acc[3:0] == 4'd0), c: fin.c};
            end
            CMD_DAA: begin
                c = fin.c;
                if (!fin.n) begin
                    if (c || bt.acc > DAA_HI_LIMIT) begin
                        r = r + DAA_HI_ADJ;
                        c = 1'b1;
                    end
                    if (fin.h || bt.acc[3:0] > DAA_LO_LIMIT) r = r + DAA_LO_ADJ;
                end else begin
                    if (c) r = r - DAA_HI_ADJ;
                    if (fin.h) r = r - DAA_LO_ADJ;
                end
                f = '{z: (r == 8'd0), n: fin.n, h: 1'b0, c: c};
            end
            CMD_CPL: begin
                r = ~bt.acc;
                f = '{z: fin.z, n: 1'b1, h: 1'b1, c: fin.c};
            end
            CMD_SCF: f = '{z: fin.z, n: 1'b0, h: 1'b0, c: 1'b1};
            CMD_CCF: f = '{z: fin.z, n: 1'b0, h: 1'b0, c: ~fin.c};
            CMD_RLCA: begin
                r = {bt.acc[6:0], bt.acc[7]};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: bt.acc[7]};
            end
            CMD_RRCA: begin
                r = {bt.acc[0], bt.acc[7:1]};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: bt.acc[0]};
            end
            CMD_RLA: begin
                r = {bt.acc[6:0], fin.c};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: bt.acc[7]};
            end
            CMD_RRA: begin
                r = {fin.c, bt.acc[7:1]};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: bt.acc[0]};
            end
            default: begin
                // undefined codes pass accumulator and flags through
                r = bt.acc;
                f = fin;
            end
        endcase
        res.result_byte = r;
        res.flags_out = f;
        return res;
    endfunction

    // byte biased toward the corners that move the flags
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        case ($urandom_range(7))
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v[3:0] = NIBBLE_MAX;
            3: v[3:0] = 4'h0;
            4: v = 8'(DAA_HI_LIMIT + $urandom_range(2) - 1);
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_beat(input logic [4:0] cmd, input logic [7:0] acc,
                             input logic [7:0] opnd, input logic [3:0] flags);
        beat_queue.push_back({cmd, acc, opnd, flags});
    endtask

    task automatic push_random(input int count);
        logic [4:0] cmd;
        for (int k = 0; k < count; k++) begin
            // mostly defined operations, now and then an undefined code
            if ($urandom_range(9) == 0) cmd = 5'($urandom_range(31, 18));
            else cmd = 5'($urandom_range(17));
            push_beat(cmd, pick_byte(), pick_byte(), 4'($urandom_range(15)));
        end
    endtask

    // wait until every queued beat has gone through and been checked
    task automatic drain();
        while (beat_queue.size() != 0 || i_in_valid || result_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: new beat at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = beat_queue.pop_front();
                i_cmd <= next_beat.cmd;
                i_acc_in <= next_beat.acc;
                i_operand_in <= next_beat.opnd;
                i_flags_in <= next_beat.flags;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, plus one long hold-off that fills the block
    always @(negedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= i_rst_n && ($urandom_range(99) < out_stall_pct);
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            result_queue.push_back(alu_eval({i_cmd, i_acc_in, i_operand_in, i_flags_in}));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                $error("unexpected output beat: result_byte %h flags_out %h",
                       o_result_byte, o_flags_out);
                fail_count = fail_count + 1;
            end else begin
                if (o_result_byte !== result_queue[0].result_byte) begin
                    $error("result_byte: expected %h, actual %h",
                           result_queue[0].result_byte, o_result_byte);
                    fail_count = fail_count + 1;
                end
                if (o_flags_out !== result_queue[0].flags_out) begin
                    $error("flags_out: expected %h, actual %h",
                           result_queue[0].flags_out, o_flags_out);
                    fail_count = fail_count + 1;
                end
                void'(result_queue.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** alu_8bit_with_flags: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_cmd = 5'd0;
        i_acc_in = 8'd0;
        i_operand_in = 8'd0;
        i_flags_in = 4'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners, no idling
        push_beat(CMD_ADD, 8'hFF, 8'h01, 4'h0);   // wrap to zero, both carries
        push_beat(CMD_ADD, 8'h00, 8'h00, 4'hF);   // zero sum
        push_beat(CMD_ADC, 8'h0F, 8'h00, 4'h1);   // carry in makes half carry
        push_beat(CMD_ADC, 8'hFF, 8'hFF, 4'h1);
        push_beat(CMD_SUB, 8'h00, 8'h01, 4'h0);   // full borrow
        push_beat(CMD_SUB, 8'h10, 8'h01, 4'h0);   // nibble borrow only
        push_beat(CMD_SBC, 8'h00, 8'h00, 4'h1);   // borrow from carry in
        push_beat(CMD_SBC, 8'h55, 8'h55, 4'h0);
        push_beat(CMD_AND, 8'hAA, 8'h55, 4'h0);
        push_beat(CMD_XOR, 8'hFF, 8'hFF, 4'hF);
        push_beat(CMD_OR, 8'h00, 8'h00, 4'hF);
        push_beat(CMD_CP, 8'h3C, 8'h3C, 4'h0);    // equal compare keeps acc
        push_beat(CMD_CP, 8'h00, 8'hFF, 4'h0);
        push_beat(CMD_INC, 8'hFF, 8'h00, 4'h1);   // wrap, carry kept
        push_beat(CMD_DEC, 8'h00, 8'h00, 4'h0);   // nibble zero, wrap
        push_beat(CMD_DEC, 8'h01, 8'h00, 4'h1);
        push_beat(CMD_DAA, 8'h9A, 8'h00, 4'h0);   // add side, both adjusts
        push_beat(CMD_DAA, 8'h99, 8'h00, 4'h0);   // add side, no adjust
        push_beat(CMD_DAA, 8'h00, 8'h00, 4'h7);   // subtract side, both adjusts
        push_beat(CMD_CPL, 8'h5A, 8'h00, 4'h9);
        push_beat(CMD_SCF, 8'h12, 8'h00, 4'h8);
        push_beat(CMD_CCF, 8'h34, 8'h00, 4'h1);
        push_beat(CMD_RLCA, 8'h80, 8'h00, 4'hF);
        push_beat(CMD_RRCA, 8'h01, 8'h00, 4'h0);
        push_beat(CMD_RLA, 8'h80, 8'h00, 4'h1);
        push_beat(CMD_RRA, 8'h01, 8'h00, 4'h1);
        push_beat(5'd31, 8'hC3, 8'hFF, 4'hA);     // undefined code
        drain();

        // random phases with different idling on each side
        send_idle_pct = 0;  out_stall_pct = 0;  push_random(90);  drain();
        send_idle_pct = 66; out_stall_pct = 0;  push_random(90);  drain();
        send_idle_pct = 0;  out_stall_pct = 66; push_random(90);  drain();
        send_idle_pct = 38; out_stall_pct = 38; push_random(90);  drain();

        // long receiver hold-off while the sender keeps offering beats
        send_idle_pct = 0;  out_stall_pct = 0;
        hold_request = 1'b1;
        push_random(40);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && result_queue.size() == 0) begin
            $display("** alu_8bit_with_flags: PASSED **");
        end else begin
            $display("** alu_8bit_with_flags: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/alu8f_pkg.sv
design/alu8f_core.sv
design/alu_8bit_with_flags.sv
dv/alu_8bit_with_flags_test.sv
